// File: rtl/core/dfq_pkg.sv
// dfq_pkg: shared types and constants for the deduplicating FIFO queue.
// Used by dfq_ring, dedup_fifo_queue_top, dfq_checker and tb; depends on nothing.
package dfq_pkg;

  // fixed field widths
  localparam int ID_W   = 6;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 7;

  // default number of identifiers held by the ring
  localparam int NUM_IDS_DEF = 64;

  // request codes
  typedef enum logic {
    ACT_ENQ = 1'b0,
    ACT_DEQ = 1'b1
  } action_t;

  // result codes
  typedef enum logic [STAT_W-1:0] {
    ST_ENQUEUED  = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_DEQUEUED  = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

endpackage

// File: rtl/core/dedup_fifo_queue_top.sv
// dedup_fifo_queue_top: FIFO of identifiers that drops enqueues of waiting ids.
// Each request passes the input register, then the result register, before out_valid.
// Throughput: one item per cycle unless a result is stalled; the oldest id is prefetched.
// Reset (rst_n low, synchronous): queue empty, presence bits clear, both channels idle.
// Ring contents are not cleared; no slot's data is used before it is written.
module dedup_fifo_queue_top #(
  parameter int NUM_IDS = dfq_pkg::NUM_IDS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // request channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_action,
  input  logic [dfq_pkg::ID_W-1:0]    in_item_id,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [dfq_pkg::ID_W-1:0]    out_id,
  output logic [dfq_pkg::STAT_W-1:0]  out_status,
  output logic [dfq_pkg::OCC_W-1:0]   out_occupancy
);

  localparam int AW      = $clog2(NUM_IDS);
  localparam int ID_SPAN = 1 << dfq_pkg::ID_W;
  localparam int PRES    = (NUM_IDS < ID_SPAN) ? NUM_IDS : ID_SPAN;
  localparam int PAW     = $clog2(PRES);

  // input stage
  logic                       s1_valid_r;
  dfq_pkg::action_t           s1_action_r;
  logic [dfq_pkg::ID_W-1:0]   s1_id_r;

  // queue state
  logic [AW-1:0]              head_r, head_nxt;
  logic [AW-1:0]              tail_r, tail_nxt;
  logic [dfq_pkg::OCC_W-1:0]  count_r, count_nxt;
  logic [PRES-1:0]            present_r, present_nxt;

  // result stage
  logic                       out_valid_r;
  logic [dfq_pkg::ID_W-1:0]   out_id_r, res_id;
  dfq_pkg::status_t           out_status_r, res_status;
  logic [dfq_pkg::OCC_W-1:0]  out_occ_r;

  logic                       advance, in_take;
  logic                       enq_ok, deq_ok, id_in_range;
  logic [dfq_pkg::ID_W-1:0]   head_data;
  logic [PAW-1:0]             id_idx, head_idx;

  // flow control: process when the result register is free or being drained
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  assign id_in_range = (32'(s1_id_r) < NUM_IDS);
  assign id_idx      = s1_id_r[PAW-1:0];
  assign head_idx    = head_data[PAW-1:0];

  // decode the held item against presence bits and occupancy
  always_comb begin
    enq_ok     = 1'b0;
    deq_ok     = 1'b0;
    res_id     = '0;
    res_status = dfq_pkg::ST_DUPLICATE;
    if (s1_action_r == dfq_pkg::ACT_ENQ) begin
      if (!id_in_range || present_r[id_idx]) begin
        res_status = dfq_pkg::ST_DUPLICATE;
      end else begin
        enq_ok     = 1'b1;
        res_status = dfq_pkg::ST_ENQUEUED;
      end
    end else begin
      if (count_r == '0) begin
        res_status = dfq_pkg::ST_EMPTY;
      end else begin
        deq_ok     = 1'b1;
        res_id     = head_data;
        res_status = dfq_pkg::ST_DEQUEUED;
      end
    end
  end

  // next queue state
  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    count_nxt   = count_r;
    present_nxt = present_r;
    if (advance && enq_ok) begin
      tail_nxt            = (tail_r == AW'(NUM_IDS - 1)) ? '0 : tail_r + 1'b1;
      count_nxt           = count_r + 1'b1;
      present_nxt[id_idx] = 1'b1;
    end
    if (advance && deq_ok) begin
      head_nxt              = (head_r == AW'(NUM_IDS - 1)) ? '0 : head_r + 1'b1;
      count_nxt             = count_r - 1'b1;
      present_nxt[head_idx] = 1'b0;
    end
  end

  // ring storage; read address follows the next head so the oldest id is ready
  dfq_ring #(
    .DEPTH (NUM_IDS)
  ) u_ring (
    .clk     (clk),
    .wr_en   (advance && enq_ok),
    .wr_addr (tail_r),
    .wr_data (s1_id_r),
    .rd_addr (head_nxt),
    .rd_data (head_data)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      present_r   <= '0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      count_r   <= count_nxt;
      present_r <= present_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_action_r <= dfq_pkg::action_t'(in_action);
      s1_id_r     <= in_item_id;
    end
    if (advance) begin
      out_id_r     <= res_id;
      out_status_r <= res_status;
      out_occ_r    <= count_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_id        = out_id_r;
  assign out_status    = out_status_r;
  assign out_occupancy = out_occ_r;

`ifndef SYNTH
  // occupancy never exceeds the ring depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= NUM_IDS)
    else $error("queue count exceeds ring depth");

  // one presence bit per waiting identifier
  a_present_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(present_r) == 32'(count_r))
    else $error("presence bits disagree with queue count");

  // an empty queue has its pointers together
  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (head_r == tail_r))
    else $error("empty queue with head and tail apart");

  // a dequeue always frees the presence bit of the id it returns
  a_deq_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && deq_ok) |=> !present_r[$past(head_idx)])
    else $error("dequeued id still marked present");
`endif

endmodule

// File: rtl/core/dfq_ring.sv
// dfq_ring: ring storage of identifiers, one write and one registered read a cycle.
// Read data bypasses a same-cycle write to the read address. Depends on dfq_pkg.
module dfq_ring #(
  parameter int DEPTH = dfq_pkg::NUM_IDS_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [dfq_pkg::ID_W-1:0]  wr_data,
  input  logic [AW-1:0]             rd_addr,
  output logic [dfq_pkg::ID_W-1:0]  rd_data
);

  logic [dfq_pkg::ID_W-1:0] mem [DEPTH];
  logic [dfq_pkg::ID_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read with write-through
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: sim/dfq_checker.sv
`timescale 1ns / 1ps
// dfq_checker: watches both channels of the deduplicating FIFO queue, predicts each result
// from its own copy of the ring and presence bits, and compares every result transfer.
// Depends on dfq_pkg for field widths, request codes and result codes.
module dfq_checker #(
  parameter int NUM_IDS = dfq_pkg::NUM_IDS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic                        in_action,
  input  logic [dfq_pkg::ID_W-1:0]    in_item_id,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [dfq_pkg::ID_W-1:0]    out_id,
  input  logic [dfq_pkg::STAT_W-1:0]  out_status,
  input  logic [dfq_pkg::OCC_W-1:0]   out_occupancy,
  output int                          mismatches,
  output int                          pending,
  output int                          results_seen,
  output int                          peak_occ,
  output int                          dup_seen,
  output int                          empty_seen
);
  import dfq_pkg::*;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    status_t          status;
    logic [OCC_W-1:0] occ;
  } queue_result_t;

  // predicted queue state
  logic [ID_W-1:0]    ring_ids [NUM_IDS];
  logic [NUM_IDS-1:0] waiting_flags;
  int                 head_idx;
  int                 tail_idx;
  int                 n_waiting;

  // results predicted but not yet seen on the output
  queue_result_t awaited_results[$];

  // apply one request to the predicted queue and return the result it gives
  function automatic queue_result_t apply_request(action_t act, logic [ID_W-1:0] id);
    queue_result_t r;
    r.id = '0;
    if (act == ACT_ENQ) begin
      if (int'(id) >= NUM_IDS || waiting_flags[id]) begin
        r.status = ST_DUPLICATE;
      end else begin
        ring_ids[tail_idx] = id;
        waiting_flags[id] = 1'b1;
        tail_idx = (tail_idx + 1) % NUM_IDS;
        n_waiting++;
        r.status = ST_ENQUEUED;
      end
    end else if (n_waiting == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.id = ring_ids[head_idx];
      if (int'(r.id) < NUM_IDS) waiting_flags[r.id] = 1'b0;
      head_idx = (head_idx + 1) % NUM_IDS;
      n_waiting--;
      r.status = ST_DEQUEUED;
    end
    r.occ = n_waiting[OCC_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    queue_result_t exp_res;
    if (!rst_n) begin
      waiting_flags = '0;
      head_idx      = 0;
      tail_idx      = 0;
      n_waiting     = 0;
      awaited_results.delete();
      mismatches    = 0;
      results_seen  = 0;
      peak_occ      = 0;
      dup_seen      = 0;
      empty_seen    = 0;
    end else begin
      // result transfer: compare against the oldest prediction
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result: out_id %0d out_status %0d out_occupancy %0d",
                 out_id, out_status, out_occupancy);
          mismatches++;
        end else begin
          exp_res = awaited_results.pop_front();
          results_seen++;
          if (out_id !== exp_res.id) begin
            $error("out_id mismatch: expected %0d, actual %0d", exp_res.id, out_id);
            mismatches++;
          end
          if (out_status !== exp_res.status) begin
            $error("out_status mismatch: expected %0d, actual %0d", exp_res.status, out_status);
            mismatches++;
          end
          if (out_occupancy !== exp_res.occ) begin
            $error("out_occupancy mismatch: expected %0d, actual %0d",
                   exp_res.occ, out_occupancy);
            mismatches++;
          end
          if (int'(exp_res.occ) > peak_occ) peak_occ = int'(exp_res.occ);
          if (exp_res.status == ST_DUPLICATE) dup_seen++;
          if (exp_res.status == ST_EMPTY) empty_seen++;
        end
      end
      // request transfer: predict its result
      if (in_valid && !in_stall) begin
        awaited_results.push_back(apply_request(action_t'(in_action), in_item_id));
      end
    end
    pending = awaited_results.size();
  end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// tb: drives requests into dedup_fifo_queue_top with random gaps and result stalls,
// and reports the verdict from dfq_checker. Depends on dfq_pkg, the block and dfq_checker.
module tb;
  import dfq_pkg::*;

  localparam int NUM_IDS    = NUM_IDS_DEF;
  localparam int IDLE_LIMIT = 2000;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              in_action;
  logic [ID_W-1:0]   in_item_id;
  logic              out_valid;
  logic              out_stall;
  logic [ID_W-1:0]   out_id;
  logic [STAT_W-1:0] out_status;
  logic [OCC_W-1:0]  out_occupancy;

  int send_idle_pct;
  int recv_idle_pct;
  int quiet_cycles;
  int enq_sent;
  int deq_sent;
  int mismatches;
  int pending;
  int results_seen;
  int peak_occ;
  int dup_seen;
  int empty_seen;

  dedup_fifo_queue_top #(.NUM_IDS(NUM_IDS)) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_action    (in_action),
    .in_item_id   (in_item_id),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_id       (out_id),
    .out_status   (out_status),
    .out_occupancy(out_occupancy)
  );

  dfq_checker #(.NUM_IDS(NUM_IDS)) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_action    (in_action),
    .in_item_id   (in_item_id),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_id       (out_id),
    .out_status   (out_status),
    .out_occupancy(out_occupancy),
    .mismatches   (mismatches),
    .pending      (pending),
    .results_seen (results_seen),
    .peak_occ     (peak_occ),
    .dup_seen     (dup_seen),
    .empty_seen   (empty_seen)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // result side back-pressure
  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < recv_idle_pct);
  end

  // watchdog: too long without any transfer ends the run
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // one request transfer, with idle cycles ahead of it
  task automatic send_item(input action_t act, input logic [ID_W-1:0] id);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_action  <= act;
    in_item_id <= id;
    if (act == ACT_ENQ) enq_sent++;
    else deq_sent++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // enqueue every identifier in random order, then drain past empty
  task automatic fill_and_drain();
    int ids [NUM_IDS];
    int j;
    int tmp;
    for (int i = 0; i < NUM_IDS; i++) ids[i] = i;
    for (int i = NUM_IDS - 1; i > 0; i--) begin
      j       = $urandom_range(i);
      tmp     = ids[i];
      ids[i]  = ids[j];
      ids[j]  = tmp;
    end
    for (int i = 0; i < NUM_IDS; i++) send_item(ACT_ENQ, ID_W'(ids[i]));
    repeat (NUM_IDS + 6) send_item(ACT_DEQ, ID_W'($urandom_range(63)));
  endtask

  // random traffic in blocks of varying enqueue/dequeue mix
  task automatic run_phase();
    int enq_pct;
    for (int b = 0; b < 10; b++) begin
      if (b == 4) fill_and_drain();
      case ($urandom_range(3))
        0:       enq_pct = 15;
        1:       enq_pct = 50;
        2:       enq_pct = 75;
        default: enq_pct = 90;
      endcase
      repeat (25) begin
        if ($urandom_range(99) < enq_pct) begin
          send_item(ACT_ENQ, ID_W'($urandom_range(NUM_IDS - 1)));
        end else begin
          send_item(ACT_DEQ, ID_W'($urandom_range(63)));
        end
      end
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_action     = ACT_ENQ;
    in_item_id    = '0;
    out_stall     = 1'b0;
    quiet_cycles  = 0;
    enq_sent      = 0;
    deq_sent      = 0;
    send_idle_pct = 36;
    recv_idle_pct = 87;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty dequeue, extreme ids, duplicates, reinsert after removal
    send_item(ACT_DEQ, 6'd0);
    send_item(ACT_ENQ, 6'd0);
    send_item(ACT_ENQ, 6'd63);
    send_item(ACT_ENQ, 6'd0);
    send_item(ACT_ENQ, 6'b101010);
    send_item(ACT_ENQ, 6'b010101);
    send_item(ACT_ENQ, 6'd63);
    send_item(ACT_DEQ, 6'd63);
    send_item(ACT_DEQ, 6'd0);
    send_item(ACT_ENQ, 6'd0);
    send_item(ACT_DEQ, 6'b010101);
    send_item(ACT_DEQ, 6'b101010);
    send_item(ACT_DEQ, 6'd0);
    send_item(ACT_DEQ, 6'd63);
    send_item(ACT_DEQ, 6'd63);

    // random: receiver idles, then sender idles, then free running
    run_phase();
    send_idle_pct = 87;
    recv_idle_pct = 36;
    run_phase();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase();
    in_valid <= 1'b0;

    // drain outstanding results
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);

    $display("Sent %0d enqueues and %0d dequeues; %0d results checked", enq_sent, deq_sent,
             results_seen);
    $display("Occupancy peaked at %0d, with %0d duplicates and %0d empty dequeues",
             peak_occ, dup_seen, empty_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: dedup_fifo_queue_top.f
rtl/core/dfq_pkg.sv
rtl/core/dfq_ring.sv
rtl/core/dedup_fifo_queue_top.sv
sim/dfq_checker.sv
sim/tb.sv
